// ===== hdl/ftra_pkg.sv =====
package ftra_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

  localparam logic CMD_ARRIVE  = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic CFG_SEAT_CAP = 1'b0;
  localparam logic CFG_SLOT_CAP = 1'b1;

  localparam logic [7:0] SEAT_CAP_RST = 8'd15;
  localparam logic [7:0] SLOT_CAP_RST = 8'd5;
  localparam logic [7:0] TICKET_RST   = 8'd1;

  localparam logic [2:0] ST_ADMITTED  = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_RELEASED  = 3'd4;
  localparam logic [2:0] ST_UNDERFLOW = 3'd5;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] ticket;
    logic [3:0] size;
    logic [7:0] free_seats;
    logic [7:0] free_slots;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

endpackage

// ===== hdl/ftra_queue.sv =====
module ftra_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ftra_pkg::qctl_t              ctl,
  input  logic [3:0]                   push_size,
  input  logic [7:0]                   push_ticket,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output logic [3:0]                   head_size,
  output logic [7:0]                   head_ticket
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [3:0]    mem_size   [DEPTH];
  logic [7:0]    mem_ticket [DEPTH];
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] tail_sum;
  logic [IW-1:0] tail;
  logic [3:0]    rd_size_r;
  logic [7:0]    rd_ticket_r;

  always_comb begin
    tail_sum = SW'(head_r) + SW'(count_r);
    if (tail_sum >= SW'(DEPTH)) begin
      tail = IW'(tail_sum - SW'(DEPTH));
    end else begin
      tail = IW'(tail_sum);
    end
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CW'(1);
      head_nxt  = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_size[tail]   <= push_size;
      mem_ticket[tail] <= push_ticket;
    end
    rd_size_r   <= mem_size[head_r];
    rd_ticket_r <= mem_ticket[head_r];
  end

  assign count       = count_r;
  assign head_size   = rd_size_r;
  assign head_ticket = rd_ticket_r;

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop)) else $error("queue push and pop together");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> count_r < CW'(DEPTH)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> count_r != '0) else $error("queue underflow");

endmodule

// ===== hdl/fifo_two_resource_admission.sv =====
// Channel  Dir  Fields
// in_      in   tuser: command; tdata: group_size [3:0]
// out_     out  tuser: status; tdata: ticket, granted_size, free_seats, free_slots;
//                tlast: last
// cfg_     in   index 0 seat_capacity, index 1 slot_capacity
// Arrival: accept, then decide and register the result.
// Release: accept, then check and free the use counts (underflow ends there);
// each head needs a registered queue read and a pass through the fit compare.
// Reset (rst_n, synchronous) empties the queue, clears use counts, ticket 1.
// A beat waiting in the output register holds the sequencer only where it must
// emit a result; in_tready is high whenever the sequencer is idle.
module fifo_two_resource_admission #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] group_size
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] ticket, [11:8] granted_size,
                                  // [19:12] free_seats, [27:20] free_slots
  output logic [2:0]  out_tuser,  // status
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NW = ftra_pkg::NW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic              cmd_r, cmd_nxt;
  logic [3:0]        size_r, size_nxt;
  logic [7:0]        tkt_r, tkt_nxt;
  logic [7:0]        seats_r, seats_nxt;
  logic [7:0]        slots_r, slots_nxt;
  logic [7:0]        seat_cap_r, slot_cap_r;
  logic [NW-1:0]     n_r, n_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  ftra_pkg::result_t pend_r, pend_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              out_last_r, out_last_nxt;
  ftra_pkg::result_t out_r, out_nxt;

  ftra_pkg::qctl_t   qctl;
  logic [CW-1:0]     q_count;
  logic [3:0]        q_size;
  logic [7:0]        q_ticket;

  logic [7:0]        fs, fsl, size8, hs8;
  logic              slot_free, fit;

  ftra_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (qctl),
    .push_size   (size_r),
    .push_ticket (tkt_r),
    .count       (q_count),
    .head_size   (q_size),
    .head_ticket (q_ticket)
  );

  always_comb begin
    fs        = (seats_r >= seat_cap_r) ? 8'd0 : seat_cap_r - seats_r;
    fsl       = (slots_r >= slot_cap_r) ? 8'd0 : slot_cap_r - slots_r;
    size8     = {4'd0, size_r};
    hs8       = {4'd0, q_size};
    slot_free = !out_vld_r || out_tready;
    fit       = (q_count != '0) && (n_r < NW'(ftra_pkg::MAX_RESULTS)) &&
                (fs >= hs8) && (fsl != 8'd0);

    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    size_nxt     = size_r;
    tkt_nxt      = tkt_r;
    seats_nxt    = seats_r;
    slots_nxt    = slots_r;
    n_nxt        = n_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_last_nxt = out_last_r;
    out_nxt      = out_r;
    qctl         = '0;
    in_tready    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          size_nxt  = in_tdata[3:0];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r == ftra_pkg::CMD_ARRIVE) begin
          if (slot_free) begin
            tkt_nxt      = tkt_r + 8'd1;
            out_vld_nxt  = 1'b1;
            out_last_nxt = 1'b1;
            out_nxt      = '{status: ftra_pkg::ST_QUEUED, ticket: tkt_r,
                             size: size_r, free_seats: fs, free_slots: fsl};
            state_nxt    = S_IDLE;
            if (size8 > seat_cap_r) begin
              out_nxt.status = ftra_pkg::ST_TOO_LARGE;
            end else if (q_count == '0 && fs >= size8 && fsl != 8'd0) begin
              seats_nxt          = seats_r + size8;
              slots_nxt          = slots_r + 8'd1;
              out_nxt.status     = ftra_pkg::ST_ADMITTED;
              out_nxt.free_seats = fs - size8;
              out_nxt.free_slots = fsl - 8'd1;
            end else if (q_count == CW'(QUEUE_DEPTH)) begin
              out_nxt.status = ftra_pkg::ST_FULL;
            end else begin
              qctl.push = 1'b1;
            end
          end
        end else if (seats_r < size8 || slots_r == 8'd0) begin
          if (slot_free) begin
            out_vld_nxt  = 1'b1;
            out_last_nxt = 1'b1;
            out_nxt      = '{status: ftra_pkg::ST_UNDERFLOW, ticket: 8'd0,
                             size: size_r, free_seats: fs, free_slots: fsl};
            state_nxt    = S_IDLE;
          end
        end else begin
          seats_nxt    = seats_r - size8;
          slots_nxt    = slots_r - 8'd1;
          n_nxt        = '0;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (fit) begin
          if (!pend_vld_r || slot_free) begin
            if (pend_vld_r) begin
              out_vld_nxt  = 1'b1;
              out_last_nxt = 1'b0;
              out_nxt      = pend_r;
            end
            pend_vld_nxt = 1'b1;
            pend_nxt     = '{status: ftra_pkg::ST_ADMITTED, ticket: q_ticket,
                             size: q_size, free_seats: fs - hs8,
                             free_slots: fsl - 8'd1};
            seats_nxt    = seats_r + hs8;
            slots_nxt    = slots_r + 8'd1;
            qctl.pop     = 1'b1;
            n_nxt        = n_r + NW'(1);
            state_nxt    = S_WAIT;
          end
        end else if (slot_free) begin
          out_vld_nxt  = 1'b1;
          out_last_nxt = 1'b1;
          if (pend_vld_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt = '{status: ftra_pkg::ST_RELEASED, ticket: 8'd0,
                        size: size_r, free_seats: fs, free_slots: fsl};
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      tkt_r      <= ftra_pkg::TICKET_RST;
      seats_r    <= '0;
      slots_r    <= '0;
      n_r        <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      seat_cap_r <= ftra_pkg::SEAT_CAP_RST;
      slot_cap_r <= ftra_pkg::SLOT_CAP_RST;
    end else begin
      state_r    <= state_nxt;
      tkt_r      <= tkt_nxt;
      seats_r    <= seats_nxt;
      slots_r    <= slots_nxt;
      n_r        <= n_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ftra_pkg::CFG_SEAT_CAP: seat_cap_r <= cfg_wdata;
          ftra_pkg::CFG_SLOT_CAP: slot_cap_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    size_r     <= size_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_r.free_slots, out_r.free_seats, out_r.size, out_r.ticket};

  a_pend_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (state_r == S_WAIT || state_r == S_DRAIN))
    else $error("pending result outside drain");
  a_drain_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(ftra_pkg::MAX_RESULTS)) else $error("drain limit exceeded");
  a_ticket_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && cmd_r == ftra_pkg::CMD_ARRIVE && slot_free)
    |=> tkt_r == $past(tkt_r) + 8'd1) else $error("ticket not advanced");
  a_pop_gated: assert property (@(posedge clk) disable iff (!rst_n)
    qctl.pop |-> (state_r == S_DRAIN && slots_r < slot_cap_r))
    else $error("admission without a free slot");

endmodule
